/* rtl/smh_pkg.sv */
// Shared types, codes and constants for the stepper motion homing controller.
// Used by smh_step and by the top level; it depends on nothing else.
package smh_pkg;

	// Number of slot positions on the carousel. A slot index above the last
	// slot is clamped to the last one.
	localparam int SLOT_COUNT = 8;
	localparam logic [3:0] SLOT_LAST = 4'(SLOT_COUNT - 1);

	// Function codes carried by the func field of an input transaction.
	localparam logic [2:0] FUNC_TICK   = 3'd0;
	localparam logic [2:0] FUNC_MOVE   = 3'd1;
	localparam logic [2:0] FUNC_SLOT   = 3'd2;
	localparam logic [2:0] FUNC_STALL  = 3'd3;
	localparam logic [2:0] FUNC_SEARCH = 3'd4;

	// Move modes for a relative move.
	localparam logic [1:0] MOVE_NORMAL = 2'd0;
	localparam logic [1:0] MOVE_SEARCH = 2'd1;
	localparam logic [1:0] MOVE_CROSS  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_COIL_0    = 3'd0;
	localparam logic [2:0] CFG_COIL_1    = 3'd1;
	localparam logic [2:0] CFG_COIL_2    = 3'd2;
	localparam logic [2:0] CFG_COIL_3    = 3'd3;
	localparam logic [2:0] CFG_SLOT_STEP = 3'd4;
	localparam logic [2:0] CFG_MIN_LOW   = 3'd5;

	typedef enum logic [1:0] {
		RUN_IDLE   = 2'd0,
		RUN_NORMAL = 2'd1,
		RUN_SEARCH = 2'd2,
		RUN_CROSS  = 2'd3
	} run_mode_t;

	typedef struct packed {
		logic [3:0][7:0] coil_pattern;
		logic [11:0]     steps_per_slot;
		logic [11:0]     min_low_ticks;
	} cfg_t;

	typedef struct packed {
		run_mode_t   run_mode;
		logic        direction_neg;
		logic [15:0] target_steps;
		logic [15:0] step_counter;
		logic [15:0] abs_position;
		logic [1:0]  phase_index;
		logic [15:0] low_tick_count;
		logic        homed_flag;
		logic        error_flag;
		logic [7:0]  coil_register;
	} state_t;

endpackage

/* rtl/smh_step.sv */
// Next-state logic of the stepper controller: applies one command or tick
// to the current state. Purely combinational; depends on smh_pkg.
module smh_step (
	input  smh_pkg::state_t st,
	input  smh_pkg::cfg_t   cfg,
	input  logic [2:0]      func,
	input  logic [15:0]     step_count,
	input  logic [1:0]      move_mode,
	input  logic [3:0]      slot_index,
	input  logic            home_sensor,
	output smh_pkg::state_t nx,
	output logic            done
);
	import smh_pkg::*;

	logic [15:0] delta;
	logic [1:0]  phase_next;
	logic [15:0] counter_next;
	logic [3:0]  slot_c;
	logic [15:0] slot_dest;
	logic [15:0] search_span;
	logic        start_en;
	logic [15:0] start_dist;
	run_mode_t   start_mode;
	logic        cross_ok;
	logic [15:0] low_next;

	assign delta        = st.direction_neg ? 16'hFFFF : 16'h0001;
	assign phase_next   = st.phase_index + (st.direction_neg ? 2'd3 : 2'd1);
	assign counter_next = st.step_counter + delta;
	assign slot_c       = (slot_index > SLOT_LAST) ? SLOT_LAST : slot_index;
	assign slot_dest    = 16'(slot_c) * 16'(cfg.steps_per_slot);
	assign search_span  = 16'(SLOT_COUNT) * 16'(cfg.steps_per_slot);
	assign low_next     = (!home_sensor && st.low_tick_count != 16'hFFFF)
		? st.low_tick_count + 16'd1 : st.low_tick_count;

	always_comb begin
		nx         = st;
		done       = 1'b0;
		start_en   = 1'b0;
		start_dist = 16'd0;
		start_mode = RUN_NORMAL;
		cross_ok   = 1'b0;

		case (func)
			FUNC_TICK: begin
				if (st.run_mode != RUN_IDLE && st.target_steps != 16'd0) begin
					nx.phase_index   = phase_next;
					nx.coil_register = cfg.coil_pattern[phase_next];
					nx.step_counter  = counter_next;
				end
				case (st.run_mode)
					RUN_NORMAL: begin
						if (st.target_steps != 16'd0) begin
							nx.abs_position = st.abs_position + delta;
							done = (counter_next == st.target_steps);
						end else begin
							done = 1'b1;
						end
					end
					RUN_SEARCH: begin
						if (st.target_steps != 16'd0) begin
							nx.abs_position = st.abs_position + delta;
							if (!home_sensor) begin
								nx.homed_flag = 1'b1;
								nx.error_flag = 1'b0;
								done = 1'b1;
							end else if (counter_next == st.target_steps) begin
								nx.homed_flag = 1'b0;
								nx.error_flag = 1'b1;
								done = 1'b1;
							end
						end
					end
					RUN_CROSS: begin
						if (st.target_steps != 16'd0) begin
							nx.low_tick_count = low_next;
							if (counter_next == st.target_steps) begin
								nx.abs_position = 16'd0;
								done = 1'b1;
							end
						end else begin
							done = 1'b1;
						end
						// The threshold is judged on the count after this tick.
						cross_ok = (nx.low_tick_count >= 16'(cfg.min_low_ticks));
						if (done) begin
							nx.homed_flag = cross_ok;
							nx.error_flag = !cross_ok;
						end
					end
					default: begin
					end
				endcase
				if (done) begin
					nx.target_steps = 16'd0;
					nx.run_mode     = RUN_IDLE;
				end
			end
			FUNC_MOVE: begin
				start_dist = step_count;
				case (move_mode)
					MOVE_NORMAL: begin
						start_en   = 1'b1;
						start_mode = RUN_NORMAL;
					end
					MOVE_SEARCH: begin
						start_en   = 1'b1;
						start_mode = RUN_SEARCH;
					end
					MOVE_CROSS: begin
						start_en   = 1'b1;
						start_mode = RUN_CROSS;
					end
					default: begin
					end
				endcase
			end
			FUNC_SLOT: begin
				start_en   = 1'b1;
				start_dist = slot_dest - st.abs_position;
				start_mode = RUN_NORMAL;
			end
			FUNC_STALL: begin
				nx.target_steps = 16'd0;
				nx.run_mode     = RUN_IDLE;
			end
			FUNC_SEARCH: begin
				start_en   = 1'b1;
				start_dist = search_span;
				start_mode = RUN_SEARCH;
			end
			default: begin
			end
		endcase

		if (start_en) begin
			if (start_dist != 16'd0) begin
				nx.direction_neg = start_dist[15];
				nx.target_steps  = start_dist;
				nx.step_counter  = 16'd0;
				if (start_mode == RUN_CROSS) begin
					nx.low_tick_count = 16'd0;
				end
				nx.run_mode = start_mode;
			end else begin
				nx.run_mode = RUN_IDLE;
			end
		end
	end

endmodule

/* rtl/stepper_motion_homing_controller_unit.sv */
// Top level of the four-phase wave-drive stepper controller with homing.
// A transaction taken at the input passes through the input register and then
// the result register; throughput is one per cycle while the result side does not stall.
// The controller state updates as an item moves into the result register.
// arst_n clears all control state and loads the documented register defaults.
// Depends on smh_pkg and smh_step.
module stepper_motion_homing_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic signed [15:0] step_count,
	input  logic [1:0]  move_mode,
	input  logic [3:0]  slot_index,
	input  logic        home_sensor,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  coil_drive,
	output logic        is_idle,
	output logic signed [15:0] position,
	output logic        homed,
	output logic        home_error,
	output logic        move_done,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import smh_pkg::*;

	// Input register stage. The payload carries no reset; only its valid bit
	// is control state.
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [15:0] step_count_s1;
	logic [1:0]  move_mode_s1;
	logic [3:0]  slot_index_s1;
	logic        home_sensor_s1;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nx;
	logic   done_nx;
	logic   advance;
	logic   in_take;

	// The item in the input register moves on whenever the result register is
	// empty or its transaction completes in this cycle. The input side can
	// therefore take a new transaction in the same cycle, so a stalled result
	// costs at most the one slot it occupies.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// Configuration writes are taken at any time; the user is to write them only while
	// the motor is at rest, and the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coil_pattern[0] <= 8'd2;
			cfg_q.coil_pattern[1] <= 8'd4;
			cfg_q.coil_pattern[2] <= 8'd1;
			cfg_q.coil_pattern[3] <= 8'd8;
			cfg_q.steps_per_slot  <= 12'd200;
			cfg_q.min_low_ticks   <= 12'd20;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COIL_0:    cfg_q.coil_pattern[0] <= cfg_data[7:0];
				CFG_COIL_1:    cfg_q.coil_pattern[1] <= cfg_data[7:0];
				CFG_COIL_2:    cfg_q.coil_pattern[2] <= cfg_data[7:0];
				CFG_COIL_3:    cfg_q.coil_pattern[3] <= cfg_data[7:0];
				CFG_SLOT_STEP: cfg_q.steps_per_slot  <= cfg_data;
				CFG_MIN_LOW:   cfg_q.min_low_ticks   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1        <= func;
			step_count_s1  <= step_count;
			move_mode_s1   <= move_mode;
			slot_index_s1  <= slot_index;
			home_sensor_s1 <= home_sensor;
		end
	end

	// One command or tick is applied to the controller state here.
	smh_step u_step (
		.st          (state_q),
		.cfg         (cfg_q),
		.func        (func_s1),
		.step_count  (step_count_s1),
		.move_mode   (move_mode_s1),
		.slot_index  (slot_index_s1),
		.home_sensor (home_sensor_s1),
		.nx          (state_nx),
		.done        (done_nx)
	);

	// Controller state. The phase index starts at the last phase so that the
	// first step lands on phase zero when moving forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.run_mode       <= RUN_IDLE;
			state_q.direction_neg  <= 1'b0;
			state_q.target_steps   <= 16'd0;
			state_q.step_counter   <= 16'd0;
			state_q.abs_position   <= 16'd0;
			state_q.phase_index    <= 2'd3;
			state_q.low_tick_count <= 16'd0;
			state_q.homed_flag     <= 1'b0;
			state_q.error_flag     <= 1'b0;
			state_q.coil_register  <= 8'd0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	// Result register. Each item yields exactly one result, which reports the
	// state as it stands after the item was applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coil_drive <= state_nx.coil_register;
			is_idle    <= (state_nx.run_mode == RUN_IDLE);
			position   <= state_nx.abs_position;
			homed      <= state_nx.homed_flag;
			home_error <= state_nx.error_flag;
			move_done  <= done_nx;
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stepper_motion_homing_controller_unit: a directed table,
// then random command and tick bursts, with each result checked against its pinned row or a motor model.
// Depends on smh_pkg and the controller RTL.
module tb;
	import smh_pkg::*;

	// Codes that the package leaves unnamed, used to check that they change nothing.
	localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
	localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
	localparam logic [1:0] MOVE_SPARE   = 2'd3;
	localparam logic [2:0] CFG_SPARE_6  = 3'd6;
	localparam logic [2:0] CFG_SPARE_7  = 3'd7;

	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 150;
	localparam int PARK_CYCLES      = 300;
	localparam int NUM_DIRECTED     = 26;

	// One input transaction.
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] step_count;
		logic [1:0]  move_mode;
		logic [3:0]  slot_index;
		logic        home_sensor;
	} stim_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]  coil_drive;
		logic        is_idle;
		logic [15:0] position;
		logic        homed;
		logic        home_error;
		logic        move_done;
	} readout_t;

	// A row of the directed table. When pinned is set, the typed readout is the
	// expectation; otherwise the motor model supplies it.
	typedef struct packed {
		stim_t    stim;
		logic     pinned;
		readout_t want;
	} dir_row_t;

	// The directed part starts from reset: default patterns 2,4,1,8, phase 3,
	// 200 steps per slot and a crossing threshold of 20.
	localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// A tick while idle and a zero-length move change nothing.
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b1,
			'{8'h00, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_MOVE, 16'h0000, MOVE_NORMAL, 4'hF, 1'b0}, 1'b1,
			'{8'h00, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0}},
		// Three forward steps walk the phases 0, 1, 2; the sensor is ignored.
		'{'{FUNC_MOVE, 16'h0003, MOVE_NORMAL, 4'h0, 1'b1}, 1'b1,
			'{8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_TICK, 16'hFFFF, MOVE_SPARE, 4'hF, 1'b1}, 1'b1,
			'{8'h02, 1'b0, 16'h0001, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b0}, 1'b1,
			'{8'h04, 1'b0, 16'h0002, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_TICK, 16'h8000, MOVE_CROSS, 4'h8, 1'b1}, 1'b1,
			'{8'h01, 1'b1, 16'h0003, 1'b0, 1'b0, 1'b1}},
		// Two steps backward.
		'{'{FUNC_MOVE, 16'hFFFE, MOVE_NORMAL, 4'h0, 1'b1}, 1'b1,
			'{8'h01, 1'b0, 16'h0003, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b1,
			'{8'h04, 1'b0, 16'h0002, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b1,
			'{8'h02, 1'b1, 16'h0001, 1'b0, 1'b0, 1'b1}},
		// Move mode three and an unused function code are ignored.
		'{'{FUNC_MOVE, 16'h0005, MOVE_SPARE, 4'h0, 1'b1}, 1'b1,
			'{8'h02, 1'b1, 16'h0001, 1'b0, 1'b0, 1'b0}},
		'{'{FUNC_SPARE_5, 16'h7FFF, MOVE_CROSS, 4'h9, 1'b0}, 1'b1,
			'{8'h02, 1'b1, 16'h0001, 1'b0, 1'b0, 1'b0}},
		// Slot 0 from position 1 wraps to a one-step move backward, then a
		// second request for slot 0 is a zero distance.
		'{'{FUNC_SLOT, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_SLOT, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		// A slot beyond the last one is clamped; the stall then ends it silently.
		'{'{FUNC_SLOT, 16'h0000, MOVE_NORMAL, 4'hF, 1'b1}, 1'b0, '0},
		'{'{FUNC_STALL, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		// Home search that finds the sensor on its first step.
		'{'{FUNC_SEARCH, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b0}, 1'b0, '0},
		// Extreme relative counts in search and crossing modes.
		'{'{FUNC_MOVE, 16'h7FFF, MOVE_SEARCH, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_MOVE, 16'h8000, MOVE_CROSS, 4'h0, 1'b1}, 1'b0, '0},
		// A short crossing with too few low ticks fails and zeroes the position.
		'{'{FUNC_MOVE, 16'h0002, MOVE_CROSS, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b0}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b0}, 1'b0, '0},
		// A search that runs into its step limit.
		'{'{FUNC_MOVE, 16'h0001, MOVE_SEARCH, 4'h0, 1'b1}, 1'b0, '0},
		'{'{FUNC_TICK, 16'h0000, MOVE_NORMAL, 4'h0, 1'b1}, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic signed [15:0] step_count;
	logic [1:0]  move_mode;
	logic [3:0]  slot_index;
	logic        home_sensor;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  coil_drive;
	logic        is_idle;
	logic signed [15:0] position;
	logic        homed;
	logic        home_error;
	logic        move_done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	stepper_motion_homing_controller_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.step_count  (step_count),
		.move_mode   (move_mode),
		.slot_index  (slot_index),
		.home_sensor (home_sensor),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coil_drive  (coil_drive),
		.is_idle     (is_idle),
		.position    (position),
		.homed       (homed),
		.home_error  (home_error),
		.move_done   (move_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Motor model: its own copy of the controller state and registers.
	state_t motor;
	cfg_t   regs;

	// Readouts predicted for accepted transactions, oldest first.
	readout_t pending_readouts[$];
	int       mismatch_count;

	// Random idling on both sides is enabled while this is set.
	bit idle_on;
	// Set by the stimulus to make the result side hold off for a long stretch.
	bit park_request;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Generous watchdog: a correct run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [15:0] step_delta();
		return motor.direction_neg ? 16'hFFFF : 16'h0001;
	endfunction

	// One motor step: advance the phase in the current direction and load its
	// coil pattern. A pattern written later only shows after the next step.
	function automatic void take_step();
		motor.phase_index   = motor.phase_index + (motor.direction_neg ? 2'd3 : 2'd1);
		motor.coil_register = regs.coil_pattern[motor.phase_index];
		motor.step_counter  = motor.step_counter + step_delta();
	endfunction

	// A zero distance only drops the controller to idle.
	function automatic void begin_move(input logic [15:0] distance, input run_mode_t mode);
		if (distance != 16'd0) begin
			motor.direction_neg = distance[15];
			motor.target_steps  = distance;
			motor.step_counter  = 16'd0;
			if (mode == RUN_CROSS)
				motor.low_tick_count = 16'd0;
			motor.run_mode = mode;
		end else begin
			motor.run_mode = RUN_IDLE;
		end
	endfunction

	// Applies one input transaction to the motor model and returns its readout.
	function automatic readout_t advance_motor(input stim_t s);
		logic       done;
		logic [3:0] slot;
		logic [31:0] dest;
		readout_t   r;
		done = 1'b0;
		case (s.func)
			FUNC_TICK: begin
				case (motor.run_mode)
					RUN_NORMAL: begin
						if (motor.target_steps != 16'd0) begin
							take_step();
							motor.abs_position = motor.abs_position + step_delta();
							done = (motor.step_counter == motor.target_steps);
						end else begin
							done = 1'b1;
						end
					end
					RUN_SEARCH: begin
						if (motor.target_steps != 16'd0) begin
							take_step();
							motor.abs_position = motor.abs_position + step_delta();
							if (!s.home_sensor) begin
								motor.homed_flag = 1'b1;
								motor.error_flag = 1'b0;
								done = 1'b1;
							end else if (motor.step_counter == motor.target_steps) begin
								motor.homed_flag = 1'b0;
								motor.error_flag = 1'b1;
								done = 1'b1;
							end
						end
					end
					RUN_CROSS: begin
						if (motor.target_steps != 16'd0) begin
							take_step();
							if (!s.home_sensor && motor.low_tick_count != 16'hFFFF)
								motor.low_tick_count = motor.low_tick_count + 16'd1;
							if (motor.step_counter == motor.target_steps) begin
								motor.abs_position = 16'd0;
								done = 1'b1;
							end
						end else begin
							done = 1'b1;
						end
						if (done) begin
							motor.homed_flag = (motor.low_tick_count >= {4'd0, regs.min_low_ticks});
							motor.error_flag = !motor.homed_flag;
						end
					end
					default: ;
				endcase
				if (done) begin
					motor.target_steps = 16'd0;
					motor.run_mode     = RUN_IDLE;
				end
			end
			FUNC_MOVE: begin
				case (s.move_mode)
					MOVE_NORMAL: begin_move(s.step_count, RUN_NORMAL);
					MOVE_SEARCH: begin_move(s.step_count, RUN_SEARCH);
					MOVE_CROSS:  begin_move(s.step_count, RUN_CROSS);
					default: ;
				endcase
			end
			FUNC_SLOT: begin
				slot = (s.slot_index > SLOT_LAST) ? SLOT_LAST : s.slot_index;
				dest = 32'(slot) * 32'(regs.steps_per_slot);
				begin_move(dest[15:0] - motor.abs_position, RUN_NORMAL);
			end
			FUNC_STALL: begin
				motor.target_steps = 16'd0;
				motor.run_mode     = RUN_IDLE;
			end
			FUNC_SEARCH: begin
				dest = 32'(SLOT_COUNT) * 32'(regs.steps_per_slot);
				begin_move(dest[15:0], RUN_SEARCH);
			end
			default: ;
		endcase
		r.coil_drive = motor.coil_register;
		r.is_idle    = (motor.run_mode == RUN_IDLE);
		r.position   = motor.abs_position;
		r.homed      = motor.homed_flag;
		r.home_error = motor.error_flag;
		r.move_done  = done;
		return r;
	endfunction

	// Offers one input transaction and waits for it to be taken. Valid is left
	// high so the next transaction can follow in the very next cycle. The
	// readout queued is the typed one for pinned rows, the model's otherwise.
	task automatic issue(input stim_t s, input logic pinned, input readout_t want);
		readout_t predicted;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= s.func;
		step_count  <= s.step_count;
		move_mode   <= s.move_mode;
		slot_index  <= s.slot_index;
		home_sensor <= s.home_sensor;
		do @(posedge clk); while (!in_ready);
		predicted = advance_motor(s);
		pending_readouts.push_back(pinned ? want : predicted);
	endtask

	// Register writes keep cfg_valid high between back-to-back transactions;
	// the caller lowers it after the last one.
	task automatic write_reg(input logic [2:0] index, input logic [11:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_COIL_0, CFG_COIL_1, CFG_COIL_2, CFG_COIL_3:
				regs.coil_pattern[index[1:0]] = data[7:0];
			CFG_SLOT_STEP: regs.steps_per_slot = data;
			CFG_MIN_LOW:   regs.min_low_ticks  = data;
			default: ;
		endcase
	endtask

	// Writes every register. The coil bytes carry random upper bits, which the
	// controller must drop.
	task automatic program_regs(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3,
			input logic [11:0] slot_step, input logic [11:0] min_low);
		write_reg(CFG_COIL_0, {4'($urandom), c0});
		write_reg(CFG_COIL_1, {4'($urandom), c1});
		write_reg(CFG_COIL_2, {4'($urandom), c2});
		write_reg(CFG_COIL_3, {4'($urandom), c3});
		write_reg(CFG_SLOT_STEP, slot_step);
		write_reg(CFG_MIN_LOW, min_low);
		cfg_valid <= 1'b0;
	endtask

	// Lets the controller drain: every queued readout must arrive before the
	// pipeline is considered idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random traffic: a command with random content, followed by a burst of
	// ticks so that most moves actually run, end, or get cut off by the next one.
	task automatic run_random(input int n_items);
		stim_t s;
		int    made;
		int    pick;
		int    burst;
		int    low_pct;
		made = 0;
		while (made < n_items) begin
			s.func        = FUNC_MOVE;
			s.step_count  = 16'($urandom);
			s.move_mode   = 2'($urandom);
			s.slot_index  = 4'($urandom);
			s.home_sensor = 1'($urandom);
			pick = $urandom_range(0, 99);
			// Relative moves are mostly short; now and then a full 16-bit count.
			if ($urandom_range(0, 9) != 0)
				s.step_count = 16'($signed($urandom_range(0, 128)) - 64);
			if (pick < 30)
				s.move_mode = MOVE_NORMAL;
			else if (pick < 45)
				s.move_mode = MOVE_CROSS;
			else if (pick < 53)
				s.move_mode = MOVE_SEARCH;
			else if (pick < 63)
				s.func = FUNC_SLOT;
			else if (pick < 70)
				s.func = FUNC_SEARCH;
			else if (pick < 76)
				s.func = FUNC_STALL;
			else if (pick < 80) begin
				if ($urandom_range(0, 1) == 0)
					s.func = 3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
				else
					s.move_mode = MOVE_SPARE;
			end else
				s.step_count = 16'd0;
			issue(s, 1'b0, '0);
			made++;

			// Some bursts hold the sensor low often enough to pass a crossing.
			low_pct = ($urandom_range(0, 3) == 0) ? 60 : 5;
			burst = $urandom_range(0, 48);
			repeat (burst) begin
				s.func        = FUNC_TICK;
				s.step_count  = 16'($urandom);
				s.move_mode   = 2'($urandom);
				s.slot_index  = 4'($urandom);
				s.home_sensor = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
				issue(s, 1'b0, '0);
				made++;
			end
		end
	endtask

	// Result side: checks every result transaction against the oldest
	// prediction, and drives out_ready with random stall bursts or a long park.
	initial begin
		int       stall_left;
		int       park_left;
		readout_t want;
		stall_left = 0;
		park_left  = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_readouts.size() == 0) begin
					$error("result transaction with no prediction waiting");
					mismatch_count++;
				end else begin
					want = pending_readouts.pop_front();
					if (coil_drive !== want.coil_drive) begin
						$error("coil_drive: expected %0h, got %0h", want.coil_drive, coil_drive);
						mismatch_count++;
					end
					if (is_idle !== want.is_idle) begin
						$error("is_idle: expected %0b, got %0b", want.is_idle, is_idle);
						mismatch_count++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d",
							$signed(want.position), position);
						mismatch_count++;
					end
					if (homed !== want.homed) begin
						$error("homed: expected %0b, got %0b", want.homed, homed);
						mismatch_count++;
					end
					if (home_error !== want.home_error) begin
						$error("home_error: expected %0b, got %0b", want.home_error, home_error);
						mismatch_count++;
					end
					if (move_done !== want.move_done) begin
						$error("move_done: expected %0b, got %0b", want.move_done, move_done);
						mismatch_count++;
					end
				end
			end
			if (park_request) begin
				park_request = 1'b0;
				park_left = PARK_CYCLES;
			end
			if (park_left > 0) begin
				park_left--;
				out_ready <= 1'b0;
			end else if (idle_on && stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases under several
	// register settings, and the final verdict.
	initial begin
		int phase;
		mismatch_count = 0;
		idle_on        = 1'b1;
		park_request   = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_TICK;
		step_count  <= '0;
		move_mode   <= MOVE_NORMAL;
		slot_index  <= '0;
		home_sensor <= 1'b1;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_COIL_0;
		cfg_data    <= '0;

		// Model state and register defaults after reset.
		motor = '0;
		motor.run_mode    = RUN_IDLE;
		motor.phase_index = 2'd3;
		regs.coil_pattern[0] = 8'd2;
		regs.coil_pattern[1] = 8'd4;
		regs.coil_pattern[2] = 8'd1;
		regs.coil_pattern[3] = 8'd8;
		regs.steps_per_slot  = 12'd200;
		regs.min_low_ticks   = 12'd20;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			issue(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
		drain();

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: program_regs(8'hFF, 8'h00, 8'hA5, 8'h5A, 12'd1, 12'd0);
				1: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					12'd4095, 12'd4095);
				2: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					12'd7, 12'd3);
				3: begin
					// The two unused register indexes must not disturb anything.
					write_reg(CFG_SPARE_6, 12'($urandom));
					write_reg(CFG_SPARE_7, 12'($urandom));
					program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
						12'($urandom_range(1, 60)), 12'($urandom_range(0, 40)));
				end
				4: program_regs(8'h01, 8'h02, 8'h04, 8'h08, 12'd200, 12'd20);
				default: program_regs(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 12'($urandom_range(1, 4095)), 12'($urandom_range(0, 30)));
			endcase
			// Phase two is a stretch without idling; the final phase runs flat out.
			idle_on = (phase != 2) && (phase != RANDOM_PHASES - 1);
			// Park the result side early in phase one while the sender keeps
			// offering, so the pipeline fills and in_ready drops.
			if (phase == 1)
				park_request = 1'b1;
			run_random(ITEMS_PER_PHASE);
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
